/* hdl/uvs_pkg.sv */
// shared types, constants and the arctangent table of the uv sphere vertex generator
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

    localparam int SEG_W       = 9;
    localparam int RAD_W       = 16;
    localparam int IDX_W       = 9;
    localparam int QUOT_BITS   = 33;
    localparam int ANG_W       = 32;
    localparam int CW          = 33;
    localparam int VW          = 32;
    localparam int POS_W       = 17;
    localparam int DIR_W       = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int SEG_MAX_DEF = 256;
    localparam int STEPS_DEF   = 16;
    localparam int SEG_MIN     = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEGMENTS = 1'd1;

    localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
    localparam logic [SEG_W-1:0] SEGMENT_RST = 9'd16;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [CW-1:0] GAIN_Q30  = 33'd652032874;
    localparam logic [CW-1:0] ONE_Q30   = 33'd1073741824;

    typedef struct packed {
        logic [SEG_W-1:0]     rem_phi;
        logic [QUOT_BITS-1:0] acc_phi;
        logic [SEG_W-1:0]     rem_th;
        logic [QUOT_BITS-1:0] acc_th;
        logic                 err;
    } div_t;

    typedef struct packed {
        logic [CW-1:0] x_phi;
        logic [CW-1:0] y_phi;
        logic [CW-1:0] z_phi;
        logic [CW-1:0] x_th;
        logic [CW-1:0] y_th;
        logic [CW-1:0] z_th;
        logic [1:0]    q_phi;
        logic [1:0]    q_th;
        logic          byp_phi;
        logic          byp_th;
        logic          err;
    } cordic_t;

    function automatic logic [CW-1:0] atan_q30(input int i);
        logic [CW-1:0] a;
        case (i)
            0:       a = 33'd843314856;
            1:       a = 33'd497837829;
            2:       a = 33'd263043836;
            3:       a = 33'd133525158;
            4:       a = 33'd67021686;
            5:       a = 33'd33543515;
            6:       a = 33'd16775850;
            7:       a = 33'd8388437;
            8:       a = 33'd4194282;
            9:       a = 33'd2097149;
            10:      a = 33'd1048575;
            11:      a = 33'd524287;
            12:      a = 33'd262143;
            13:      a = 33'd131071;
            14:      a = 33'd65535;
            15:      a = 33'd32767;
            16:      a = 33'd16383;
            17:      a = 33'd8191;
            18:      a = 33'd4095;
            19:      a = 33'd2047;
            20:      a = 33'd1023;
            21:      a = 33'd511;
            22:      a = 33'd255;
            23:      a = 33'd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

/* hdl/uvs_div_cell.sv */
// one restoring division step for the latitude and longitude angle lanes
`timescale 1ns / 1ps
`default_nettype none
module uvs_div_cell
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [uvs_pkg::SEG_W-1:0] divisor,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire uvs_pkg::div_t           in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output uvs_pkg::div_t                out_data
);

    logic          valid_reg;
    uvs_pkg::div_t data_reg;
    uvs_pkg::div_t data_next;
    logic [uvs_pkg::SEG_W:0] t_phi;
    logic [uvs_pkg::SEG_W:0] t_th;
    logic ge_phi;
    logic ge_th;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        t_phi  = {in_data.rem_phi, in_data.acc_phi[uvs_pkg::QUOT_BITS-1]};
        t_th   = {in_data.rem_th, in_data.acc_th[uvs_pkg::QUOT_BITS-1]};
        ge_phi = t_phi >= {1'b0, divisor};
        ge_th  = t_th >= {1'b0, divisor};
        data_next         = in_data;
        data_next.rem_phi = ge_phi ? uvs_pkg::SEG_W'(t_phi - {1'b0, divisor})
                                   : t_phi[uvs_pkg::SEG_W-1:0];
        data_next.acc_phi = {in_data.acc_phi[uvs_pkg::QUOT_BITS-2:0], ge_phi};
        data_next.rem_th  = ge_th ? uvs_pkg::SEG_W'(t_th - {1'b0, divisor})
                                  : t_th[uvs_pkg::SEG_W-1:0];
        data_next.acc_th  = {in_data.acc_th[uvs_pkg::QUOT_BITS-2:0], ge_th};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/uvs_cordic_cell.sv */
// one cordic rotation step for the latitude and longitude angle lanes
`timescale 1ns / 1ps
`default_nettype none
module uvs_cordic_cell
#(
    parameter int STEP = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire uvs_pkg::cordic_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output uvs_pkg::cordic_t      out_data
);

    localparam logic [uvs_pkg::CW-1:0] ATAN = uvs_pkg::atan_q30(STEP);

    logic             valid_reg;
    uvs_pkg::cordic_t data_reg;
    uvs_pkg::cordic_t data_next;
    logic signed [uvs_pkg::CW-1:0] xp, yp, xt, yt, dxp, dyp, dxt, dyt;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        xp  = $signed(in_data.x_phi);
        yp  = $signed(in_data.y_phi);
        xt  = $signed(in_data.x_th);
        yt  = $signed(in_data.y_th);
        dxp = yp >>> STEP;
        dyp = xp >>> STEP;
        dxt = yt >>> STEP;
        dyt = xt >>> STEP;
        data_next = in_data;
        if (!in_data.z_phi[uvs_pkg::CW-1])
        begin
            data_next.x_phi = in_data.x_phi - dxp;
            data_next.y_phi = in_data.y_phi + dyp;
            data_next.z_phi = in_data.z_phi - ATAN;
        end
        else
        begin
            data_next.x_phi = in_data.x_phi + dxp;
            data_next.y_phi = in_data.y_phi - dyp;
            data_next.z_phi = in_data.z_phi + ATAN;
        end
        if (!in_data.z_th[uvs_pkg::CW-1])
        begin
            data_next.x_th = in_data.x_th - dxt;
            data_next.y_th = in_data.y_th + dyt;
            data_next.z_th = in_data.z_th - ATAN;
        end
        else
        begin
            data_next.x_th = in_data.x_th + dxt;
            data_next.y_th = in_data.y_th - dyt;
            data_next.z_th = in_data.z_th + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/uv_sphere_vertex_generator_unit.sv */
// top level of the uv sphere vertex generator: angle divider, cordic row and output math
// pipeline: 33 divider cells + 1 angle scale + CORDIC_STEPS cordic cells + 3 output stages
// throughput: one item per cycle while m_tready is high; every cell is a pipeline stage with its own valid bit
// stages with no item pass bubbles forward, so items are accepted while a result waits until the row is full
// reset: asynchronous active low, radius returns to 256 and segment count to 16
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_vertex_generator_unit
#(
    parameter int SEG_MAX      = uvs_pkg::SEG_MAX_DEF,
    parameter int CORDIC_STEPS = uvs_pkg::STEPS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [uvs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [uvs_pkg::RAD_W-1:0]       cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // lat_index, lon_index
    input  wire logic [23:0]                     s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tan_x, tan_z
    output logic [135:0]                         m_tdata,
    // index_error
    output logic                                 m_tuser
);

    localparam int NQ = uvs_pkg::QUOT_BITS;
    localparam int CW = uvs_pkg::CW;
    localparam int VW = uvs_pkg::VW;

    logic [uvs_pkg::RAD_W-1:0] radius_reg;
    logic [uvs_pkg::SEG_W-1:0] segment_reg;
    logic [uvs_pkg::SEG_W-1:0] seg_eff;
    logic [uvs_pkg::IDX_W-1:0] lat;
    logic [uvs_pkg::IDX_W-1:0] lon;

    uvs_pkg::div_t    div_d [0:NQ];
    logic             div_v [0:NQ];
    logic             div_r [0:NQ];
    uvs_pkg::cordic_t cor_d [0:CORDIC_STEPS];
    logic             cor_v [0:CORDIC_STEPS];
    logic             cor_r [0:CORDIC_STEPS];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= uvs_pkg::RADIUS_RST;
            segment_reg <= uvs_pkg::SEGMENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                uvs_pkg::REG_RADIUS:   radius_reg  <= cfg_data;
                uvs_pkg::REG_SEGMENTS: segment_reg <= cfg_data[uvs_pkg::SEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (int'(segment_reg) < uvs_pkg::SEG_MIN)
            seg_eff = uvs_pkg::SEG_W'(uvs_pkg::SEG_MIN);
        else if (int'(segment_reg) > SEG_MAX)
            seg_eff = uvs_pkg::SEG_W'(SEG_MAX);
        else
            seg_eff = segment_reg;
    end

    // divider feed: dividends lat*2^31 + s/2 and lon*2^32 + s/2
    assign lat = s_tdata[8:0];
    assign lon = s_tdata[17:9];

    always_comb
    begin
        logic [40:0] n_phi;
        logic [40:0] n_th;
        n_phi = {1'b0, lat, 31'd0} | 41'(seg_eff >> 1);
        n_th  = {lon, 32'd0} | 41'(seg_eff >> 1);
        div_d[0].rem_phi = {1'b0, n_phi[40:33]};
        div_d[0].acc_phi = n_phi[32:0];
        div_d[0].rem_th  = {1'b0, n_th[40:33]};
        div_d[0].acc_th  = n_th[32:0];
        div_d[0].err     = (lat > seg_eff) || (lon > seg_eff);
    end

    assign div_v[0] = s_tvalid;
    assign s_tready = div_r[0];

    genvar gi;
    generate
        for (gi = 0; gi < NQ; gi++)
        begin : g_div
            uvs_div_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .divisor   (seg_eff),
                .in_valid  (div_v[gi]),
                .in_ready  (div_r[gi]),
                .in_data   (div_d[gi]),
                .out_valid (div_v[gi+1]),
                .out_ready (div_r[gi+1]),
                .out_data  (div_d[gi+1])
            );
        end
    endgenerate

    // angle to radians, cordic seed
    logic             ang_v_reg;
    uvs_pkg::cordic_t ang_reg;
    uvs_pkg::cordic_t ang_next;
    logic             ang_rdy;

    assign ang_rdy      = !ang_v_reg || cor_r[0];
    assign div_r[NQ]    = ang_rdy;

    always_comb
    begin
        logic [31:0] a_phi;
        logic [31:0] a_th;
        logic [60:0] p_phi;
        logic [60:0] p_th;
        a_phi = div_d[NQ].acc_phi[31:0];
        a_th  = div_d[NQ].acc_th[31:0];
        p_phi = 61'(a_phi[29:0]) * 61'(uvs_pkg::HALF_PI_Q30) + 61'(32'h2000_0000);
        p_th  = 61'(a_th[29:0]) * 61'(uvs_pkg::HALF_PI_Q30) + 61'(32'h2000_0000);
        ang_next.x_phi   = uvs_pkg::GAIN_Q30;
        ang_next.y_phi   = '0;
        ang_next.z_phi   = {2'b00, p_phi[60:30]};
        ang_next.x_th    = uvs_pkg::GAIN_Q30;
        ang_next.y_th    = '0;
        ang_next.z_th    = {2'b00, p_th[60:30]};
        ang_next.q_phi   = a_phi[31:30];
        ang_next.q_th    = a_th[31:30];
        ang_next.byp_phi = a_phi[29:0] == '0;
        ang_next.byp_th  = a_th[29:0] == '0;
        ang_next.err     = div_d[NQ].err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_v_reg <= 1'b0;
        else if (ang_rdy)
            ang_v_reg <= div_v[NQ];
    end

    always_ff @(posedge clk)
    begin
        if (ang_rdy && div_v[NQ])
            ang_reg <= ang_next;
    end

    assign cor_v[0] = ang_v_reg;
    assign cor_d[0] = ang_reg;

    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++)
        begin : g_cordic
            uvs_cordic_cell #(.STEP(gi)) u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (cor_v[gi]),
                .in_ready  (cor_r[gi]),
                .in_data   (cor_d[gi]),
                .out_valid (cor_v[gi+1]),
                .out_ready (cor_r[gi+1]),
                .out_data  (cor_d[gi+1])
            );
        end
    endgenerate

    // clamp and quadrant fold
    logic fold_v_reg;
    logic fold_rdy;
    logic signed [VW-1:0] cphi_reg, sphi_reg, cth_reg, sth_reg;
    logic signed [VW-1:0] cphi_next, sphi_next, cth_next, sth_next;
    logic fold_err_reg;

    function automatic logic signed [CW-1:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > $signed(uvs_pkg::ONE_Q30))
            r = $signed(uvs_pkg::ONE_Q30);
        else if (v < -$signed(uvs_pkg::ONE_Q30))
            r = -$signed(uvs_pkg::ONE_Q30);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [2*VW-1:0] fold(input logic [CW-1:0] x_in,
                                             input logic [CW-1:0] y_in,
                                             input logic [1:0] q, input logic byp);
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] co;
        logic signed [CW-1:0] si;
        x = byp ? $signed(uvs_pkg::ONE_Q30) : clamp_unit($signed(x_in));
        y = byp ? '0 : clamp_unit($signed(y_in));
        case (q)
            2'd0:    begin co = x;  si = y;  end
            2'd1:    begin co = -y; si = x;  end
            2'd2:    begin co = -x; si = -y; end
            default: begin co = y;  si = -x; end
        endcase
        return {co[VW-1:0], si[VW-1:0]};
    endfunction

    always_comb
    begin
        {cphi_next, sphi_next} = fold(cor_d[CORDIC_STEPS].x_phi, cor_d[CORDIC_STEPS].y_phi,
                                      cor_d[CORDIC_STEPS].q_phi, cor_d[CORDIC_STEPS].byp_phi);
        {cth_next, sth_next}   = fold(cor_d[CORDIC_STEPS].x_th, cor_d[CORDIC_STEPS].y_th,
                                      cor_d[CORDIC_STEPS].q_th, cor_d[CORDIC_STEPS].byp_th);
    end

    logic mul_v_reg;
    logic mul_rdy;
    assign fold_rdy            = !fold_v_reg || mul_rdy;
    assign cor_r[CORDIC_STEPS] = fold_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_v_reg <= 1'b0;
        else if (fold_rdy)
            fold_v_reg <= cor_v[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (fold_rdy && cor_v[CORDIC_STEPS])
        begin
            cphi_reg     <= cphi_next;
            sphi_reg     <= sphi_next;
            cth_reg      <= cth_next;
            sth_reg      <= sth_next;
            fold_err_reg <= cor_d[CORDIC_STEPS].err;
        end
    end

    // q30 products
    logic signed [VW-1:0] sc_reg, ss_reg, mcphi_reg, mcth_reg, msth_reg;
    logic signed [VW-1:0] sc_next, ss_next;
    logic mul_err_reg;
    logic out_v_reg;
    logic out_rdy;

    always_comb
    begin
        logic signed [2*VW-1:0] p_c;
        logic signed [2*VW-1:0] p_s;
        p_c = 64'(sphi_reg) * 64'(cth_reg) + 64'sd536870912;
        p_s = 64'(sphi_reg) * 64'(sth_reg) + 64'sd536870912;
        sc_next = p_c[61:30];
        ss_next = p_s[61:30];
    end

    assign mul_rdy = !mul_v_reg || out_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else if (mul_rdy)
            mul_v_reg <= fold_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mul_rdy && fold_v_reg)
        begin
            sc_reg      <= sc_next;
            ss_reg      <= ss_next;
            mcphi_reg   <= cphi_reg;
            mcth_reg    <= cth_reg;
            msth_reg    <= sth_reg;
            mul_err_reg <= fold_err_reg;
        end
    end

    // scaling to output formats, output register
    logic [uvs_pkg::POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [uvs_pkg::DIR_W-1:0] norm_x_reg, norm_y_reg, norm_z_reg, tan_x_reg, tan_z_reg;
    logic                      err_reg;
    logic [uvs_pkg::POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [uvs_pkg::DIR_W-1:0] norm_x_next, norm_y_next, norm_z_next, tan_x_next, tan_z_next;

    function automatic logic [uvs_pkg::POS_W-1:0] to_pos(input logic [uvs_pkg::RAD_W-1:0] r,
                                                         input logic signed [VW-1:0] v);
        logic signed [48:0] p;
        p = 49'(signed'({1'b0, r})) * 49'(v) + 49'sd536870912;
        return p[46:30];
    endfunction

    function automatic logic [uvs_pkg::DIR_W-1:0] to_q14(input logic signed [VW-1:0] v);
        logic signed [VW:0] w;
        w = 33'(v) + 33'sd32768;
        return w[31:16];
    endfunction

    always_comb
    begin
        logic kill;
        kill        = mul_err_reg || (radius_reg == '0);
        pos_x_next  = kill ? '0 : to_pos(radius_reg, sc_reg);
        pos_y_next  = kill ? '0 : to_pos(radius_reg, mcphi_reg);
        pos_z_next  = kill ? '0 : to_pos(radius_reg, ss_reg);
        norm_x_next = kill ? '0 : to_q14(sc_reg);
        norm_y_next = kill ? '0 : to_q14(mcphi_reg);
        norm_z_next = kill ? '0 : to_q14(ss_reg);
        tan_x_next  = kill ? '0 : to_q14(-msth_reg);
        tan_z_next  = kill ? '0 : to_q14(mcth_reg);
    end

    assign out_rdy = !out_v_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_rdy)
            out_v_reg <= mul_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && mul_v_reg)
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            norm_x_reg <= norm_x_next;
            norm_y_reg <= norm_y_next;
            norm_z_reg <= norm_z_next;
            tan_x_reg  <= tan_x_next;
            tan_z_reg  <= tan_z_next;
            err_reg    <= mul_err_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = err_reg;
    assign m_tdata  = {5'd0, tan_z_reg, tan_x_reg, norm_z_reg, norm_y_reg, norm_x_reg,
                       pos_z_reg, pos_y_reg, pos_x_reg};

    // an empty output register lets the whole row move
    assert property (@(posedge clk) disable iff (!rst_n) !out_v_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // an index error result carries no geometry
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && err_reg) |-> (pos_x_reg == '0 && pos_y_reg == '0 && norm_y_reg == '0
                                    && tan_z_reg == '0))
        else $error("index error result with nonzero fields");

    // a new result comes only from the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(mul_v_reg))
        else $error("result appeared without a source item");

endmodule
`default_nettype wire
